// File: hdl/dcc_pkg.sv
// dcc_pkg: item types and action codes for the depthwise causal conv stream
// used by depthwise_causal_conv_stream and dcc_checker
package dcc_pkg;

  localparam int VAL_W = 16;
  localparam int CH_W  = 13;
  localparam int ACT_W = 2;
  localparam int TAP_W = 2;
  localparam int KS_W  = 3;
  localparam int FRAC_SHIFT = 14;

  localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WTAP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HIST   = 2'd2;

  localparam logic [KS_W-1:0] KS_RESET = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [CH_W-1:0]         channel;
    logic [TAP_W-1:0]        tap;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result;
    logic [CH_W-1:0]         out_channel;
    logic                    saturated;
  } out_item_t;

endpackage

// File: hdl/dcc_ram.sv
// dcc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/depthwise_causal_conv_stream.sv
// depthwise_causal_conv_stream: per-channel causal fir, weights and history in ram
// depends on dcc_pkg and dcc_ram
// an accepted sample item passes the s1, s2 and output registers to out_valid
// throughput: one item per cycle while in_stall is low; each ram does one read-modify-write per item
// reset: history ram is zeroed by a pass over all CHANNELS rows with in_stall high
// weights are not cleared; the tap count resets to 4
module depthwise_causal_conv_stream #(
  parameter int CHANNELS = 8192,
  parameter int MAX_TAPS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  dcc_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output dcc_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dcc_pkg::KS_W-1:0]  cfg_data
);

  localparam int VW     = dcc_pkg::VAL_W;
  localparam int HR     = MAX_TAPS - 1;
  localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_CW = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = 2 * VW;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);

  logic                    en;
  logic                    accept;
  logic [dcc_pkg::KS_W-1:0] ntaps_r;
  logic [TAP_CW-1:0]       k_taps;
  logic [TAP_CW-1:0]       pad;

  logic                    clr_active_r;
  logic [CH_AW-1:0]        clr_cnt_r;

  logic                    s1_vld_r;
  dcc_pkg::in_item_t       s1_item_r;
  logic [CH_AW-1:0]        s1_addr;
  logic [CH_AW-1:0]        rd_addr;

  logic [MAX_TAPS-1:0][VW-1:0] w_rdata, w_row, w_new, wwb_row_r;
  logic [HR-1:0][VW-1:0]       h_rdata, h_row, h_new, hwb_row_r;
  logic                    wwb_vld_r, hwb_vld_r;
  logic [CH_AW-1:0]        wwb_addr_r, hwb_addr_r;

  logic                    ch_ok, is_samp, is_w, is_h;
  logic                    w_we, h_we, h_ram_we;
  logic [CH_AW-1:0]        h_waddr;
  logic [HR*VW-1:0]        h_wdata;

  logic signed [PROD_W-1:0] prod [MAX_TAPS];
  logic                    s2_vld_r;
  logic [dcc_pkg::CH_W-1:0] s2_ch_r;
  logic signed [PROD_W-1:0] s2_prod_r [MAX_TAPS];

  logic signed [ACC_W-1:0] acc, acc_sh;
  logic                    sat_hi, sat_lo;
  logic signed [VW-1:0]    res;

  logic                    out_vld_r;
  dcc_pkg::out_item_t      out_item_r;

  assign en        = !(out_vld_r && out_stall);
  assign in_stall  = clr_active_r || !en;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (ntaps_r == '0) begin
      k_taps = TAP_CW'(1);
    end else if (32'(ntaps_r) > MAX_TAPS) begin
      k_taps = TAP_CW'(MAX_TAPS);
    end else begin
      k_taps = TAP_CW'(ntaps_r);
    end
  end
  assign pad = k_taps - TAP_CW'(1);

  assign s1_addr = CH_AW'(s1_item_r.channel);
  assign rd_addr = en ? CH_AW'(in_item.channel) : s1_addr;

  dcc_ram #(.WIDTH(MAX_TAPS * VW), .DEPTH(CHANNELS)) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (s1_addr),
    .wdata (w_new),
    .raddr (rd_addr),
    .rdata (w_rdata)
  );

  dcc_ram #(.WIDTH(HR * VW), .DEPTH(CHANNELS)) u_hram (
    .clk   (clk),
    .we    (h_ram_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (rd_addr),
    .rdata (h_rdata)
  );

  // forward the latest write where the ram read may be stale
  assign w_row = (wwb_vld_r && wwb_addr_r == s1_addr) ? wwb_row_r : w_rdata;
  assign h_row = (hwb_vld_r && hwb_addr_r == s1_addr) ? hwb_row_r : h_rdata;

  assign ch_ok   = 32'(s1_item_r.channel) < CHANNELS;
  assign is_samp = s1_vld_r && ch_ok && s1_item_r.action == dcc_pkg::ACT_SAMPLE;
  assign is_w    = s1_vld_r && ch_ok && s1_item_r.action == dcc_pkg::ACT_WTAP
                   && 32'(s1_item_r.tap) < MAX_TAPS;
  assign is_h    = s1_vld_r && ch_ok && s1_item_r.action == dcc_pkg::ACT_HIST
                   && 32'(s1_item_r.tap) < HR;

  assign w_we = en && is_w;
  assign h_we = en && (is_h || (is_samp && pad != '0));

  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      w_new[i] = (32'(s1_item_r.tap) == i) ? s1_item_r.value : w_row[i];
    end
  end

  always_comb begin
    for (int i = 0; i < HR; i++) begin
      if (is_h) begin
        h_new[i] = (32'(s1_item_r.tap) == i) ? s1_item_r.value : h_row[i];
      end else if (i + 1 < 32'(pad)) begin
        h_new[i] = h_row[i + 1];
      end else if (i + 1 == 32'(pad)) begin
        h_new[i] = s1_item_r.value;
      end else begin
        h_new[i] = h_row[i];
      end
    end
  end

  assign h_ram_we = clr_active_r || h_we;
  assign h_waddr  = clr_active_r ? clr_cnt_r : s1_addr;
  assign h_wdata  = clr_active_r ? '0 : h_new;

  // lag k uses history row pad-k; taps past the live count are not read
  always_comb begin
    logic signed [VW-1:0] opnd;
    prod[0] = $signed(w_row[0]) * s1_item_r.value;
    for (int k = 1; k < MAX_TAPS; k++) begin
      opnd = '0;
      for (int j = 0; j < HR; j++) begin
        if (k < 32'(k_taps) && j + k == 32'(pad)) begin
          opnd = h_row[j];
        end
      end
      if (k < 32'(k_taps)) begin
        prod[k] = $signed(w_row[k]) * opnd;
      end else begin
        prod[k] = '0;
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      acc = acc + ACC_W'(s2_prod_r[k]);
    end
  end
  assign acc_sh = (acc + ACC_W'(1 << (dcc_pkg::FRAC_SHIFT - 1))) >>> dcc_pkg::FRAC_SHIFT;
  assign sat_hi = !acc_sh[ACC_W-1] && (|acc_sh[ACC_W-2:VW-1]);
  assign sat_lo = acc_sh[ACC_W-1] && !(&acc_sh[ACC_W-2:VW-1]);
  assign res    = sat_hi ? {1'b0, {(VW-1){1'b1}}}
                : sat_lo ? {1'b1, {(VW-1){1'b0}}}
                : acc_sh[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntaps_r       <= dcc_pkg::KS_RESET;
      clr_active_r  <= 1'b1;
      clr_cnt_r     <= '0;
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      wwb_vld_r     <= 1'b0;
      hwb_vld_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ntaps_r <= cfg_data;
      end
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + CH_AW'(1);
        if (clr_cnt_r == CH_AW'(CHANNELS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (w_we) begin
        wwb_vld_r <= 1'b1;
      end
      if (h_we) begin
        hwb_vld_r <= 1'b1;
      end
      if (en) begin
        s1_vld_r  <= accept;
        s2_vld_r  <= is_samp;
        out_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wwb_addr_r <= s1_addr;
      wwb_row_r  <= w_new;
    end
    if (h_we) begin
      hwb_addr_r <= s1_addr;
      hwb_row_r  <= h_new;
    end
    if (en) begin
      s1_item_r <= in_item;
      s2_ch_r   <= s1_item_r.channel;
      for (int k = 0; k < MAX_TAPS; k++) begin
        s2_prod_r[k] <= prod[k];
      end
      if (s2_vld_r) begin
        out_item_r.result      <= res;
        out_item_r.out_channel <= s2_ch_r;
        out_item_r.saturated   <= sat_hi || sat_lo;
      end
    end
  end

endmodule

// File: hdl/dcc_checker.sv
// dcc_port_props: port-level assertions for depthwise_causal_conv_stream
// depends on dcc_pkg; bound to the top level below
module dcc_port_props (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input dcc_pkg::out_item_t       out_item
);

  // result held while the sink stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // history clear keeps the input closed right after reset
  a_clr_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during history clear");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // saturation flag only with a clipped value
  a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      out_item.result == 16'sh7fff || out_item.result == -16'sh8000)
    else $error("saturated flag with unclipped result");

endmodule

bind depthwise_causal_conv_stream dcc_port_props u_dcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
